// File: rtl/rmsont_pkg.sv
package rmsont_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int COUNT_BITS  = 16;

  localparam int IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_W = 22;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  localparam int COEFF_W = 24;
  localparam int MS_W    = 31;
  localparam logic [MS_W-1:0] MS_MAX = {MS_W{1'b1}};

  // shared multiplier: signed A x signed B, result registered
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = (SAMPLE_BITS + 1 > COEFF_W + 1) ? SAMPLE_BITS + 1 : COEFF_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam int SQ_SHIFT   = 2 * SAMPLE_BITS - 32;
  localparam int DIFF_W     = MS_W + 2;
  localparam int DELTA_W    = PROD_W - COEFF_W;

  localparam int TAB_W    = 18;
  localparam int INTERP_W = 13;
  localparam int LG_W     = 24;
  localparam int Y_W      = 24;
  localparam int IP_W     = Y_W - 16;
  localparam int POW_W    = 19;
  localparam int TERM_W   = 13;
  localparam int VSUM_W   = TERM_W + 1;

  localparam int NORM_STEPS = 5;
  localparam int NORM_CNT_W = 3;

  localparam logic [31:0] CNT_MAX = (32'd1 << COUNT_BITS) - 32'd1;

  localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;
  localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
  localparam logic [6:0] VEL_MAX         = 7'h7f;
  localparam logic [9:0] VSCALE_MAX      = 10'd540;
  localparam logic [8:0] VEXP_MAX        = 9'd256;
  localparam logic [15:0] OFF_TICKS_MIN  = 16'd5;
  localparam logic [15:0] VOL_TICKS_MIN  = 16'd1;
  localparam logic [POW_W-1:0] POW_ONE   = POW_W'(65536);

  localparam logic [COEFF_W-1:0] RST_COEFF  = 24'd32918;
  localparam logic [MS_W-1:0]    RST_THRESH = 31'd10737418;
  localparam logic [15:0]        RST_OFF    = 16'd2400;
  localparam logic [15:0]        RST_VOL    = 16'd720;
  localparam logic [6:0]         RST_NOTE   = 7'd36;
  localparam logic [6:0]         RST_VMIN   = 7'd16;
  localparam logic [9:0]         RST_VSCALE = 10'd140;
  localparam logic [8:0]         RST_VEXP   = 9'd154;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SMOOTH    = 3'd0,
    REG_THRESH    = 3'd1,
    REG_OFF_TICKS = 3'd2,
    REG_VOL_TICKS = 3'd3,
    REG_NOTE      = 3'd4,
    REG_VMIN      = 3'd5,
    REG_VSCALE    = 3'd6,
    REG_VEXP      = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [COEFF_W-1:0]    coeff;
    logic [MS_W-1:0]       thresh;
    logic [COUNT_BITS-1:0] off_ticks;
    logic [COUNT_BITS-1:0] vol_ticks;
    logic [6:0]            note;
    logic [6:0]            vmin;
    logic [9:0]            vscale;
    logic [8:0]            vexp;
  } cfg_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_SQ,
    MUL_COEF,
    MUL_LOGI,
    MUL_LOGE,
    MUL_EXPI,
    MUL_VSC
  } mul_sel_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SQ,
    S_SQCAP,
    S_MSMUL,
    S_UPD,
    S_DECIDE,
    S_POW0,
    S_NORM,
    S_LOGI,
    S_LOGA,
    S_LOGM,
    S_YCAP,
    S_EXPI,
    S_EXPM,
    S_SCALE,
    S_VEL,
    S_EMIT_ON,
    S_EMIT_OFF
  } state_t;

  typedef struct packed {
    logic                  load_sample;
    mul_sel_t              mul_sel;
    logic                  cap_sq;
    logic                  upd_ms;
    logic                  decide;
    logic                  pow_init;
    logic                  norm_step;
    logic [NORM_CNT_W-1:0] norm_idx;
    logic                  cap_lg;
    logic                  cap_y;
    logic                  cap_pow;
    logic                  cap_vel;
    logic                  out_load;
    logic                  out_on;
  } cmd_t;

  typedef struct packed {
    logic note_on;
    logic note_off;
    logic pow_special;
    logic out_free;
  } sts_t;

  // log2(1 + k/16), Q16
  function automatic logic [TAB_W-1:0] log_tab(input logic [4:0] k);
    logic [TAB_W-1:0] v;
    case (k)
      5'd0:    v = 18'd0;
      5'd1:    v = 18'd5732;
      5'd2:    v = 18'd11136;
      5'd3:    v = 18'd16248;
      5'd4:    v = 18'd21098;
      5'd5:    v = 18'd25711;
      5'd6:    v = 18'd30109;
      5'd7:    v = 18'd34312;
      5'd8:    v = 18'd38336;
      5'd9:    v = 18'd42196;
      5'd10:   v = 18'd45904;
      5'd11:   v = 18'd49473;
      5'd12:   v = 18'd52911;
      5'd13:   v = 18'd56229;
      5'd14:   v = 18'd59434;
      5'd15:   v = 18'd62535;
      5'd16:   v = 18'd65536;
      default: v = 18'd0;
    endcase
    return v;
  endfunction

  // 2^(k/16), Q16
  function automatic logic [TAB_W-1:0] exp_tab(input logic [4:0] k);
    logic [TAB_W-1:0] v;
    case (k)
      5'd0:    v = 18'd65536;
      5'd1:    v = 18'd68438;
      5'd2:    v = 18'd71468;
      5'd3:    v = 18'd74632;
      5'd4:    v = 18'd77936;
      5'd5:    v = 18'd81386;
      5'd6:    v = 18'd84990;
      5'd7:    v = 18'd88752;
      5'd8:    v = 18'd92682;
      5'd9:    v = 18'd96785;
      5'd10:   v = 18'd101070;
      5'd11:   v = 18'd105545;
      5'd12:   v = 18'd110218;
      5'd13:   v = 18'd115098;
      5'd14:   v = 18'd120194;
      5'd15:   v = 18'd125515;
      5'd16:   v = 18'd131072;
      default: v = 18'd0;
    endcase
    return v;
  endfunction

  // count register: saturate to counter range, then apply the floor
  function automatic logic [COUNT_BITS-1:0] sat_cnt(input logic [15:0] v,
                                                    input logic [15:0] lo);
    logic [31:0] t;
    t = 32'(v);
    if (t > CNT_MAX) t = CNT_MAX;
    if (t < 32'(lo)) t = 32'(lo);
    return t[COUNT_BITS-1:0];
  endfunction

endpackage

// File: rtl/rmsont_cfg.sv
module rmsont_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [rmsont_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rmsont_pkg::CFG_DATA_W-1:0] cfg_data,
  output rmsont_pkg::cfg_t                 cfg
);
  import rmsont_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  // values are stored already clamped to their legal range
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SMOOTH:    cfg_nxt.coeff     = cfg_data[COEFF_W-1:0];
        REG_THRESH:    cfg_nxt.thresh    = cfg_data[MS_W-1:0];
        REG_OFF_TICKS: cfg_nxt.off_ticks = sat_cnt(cfg_data[15:0], OFF_TICKS_MIN);
        REG_VOL_TICKS: cfg_nxt.vol_ticks = sat_cnt(cfg_data[15:0], VOL_TICKS_MIN);
        REG_NOTE:      cfg_nxt.note      = cfg_data[6:0];
        REG_VMIN:      cfg_nxt.vmin      = (cfg_data[6:0] == 7'd0) ? 7'd1 : cfg_data[6:0];
        REG_VSCALE:    cfg_nxt.vscale    = (cfg_data[9:0] > VSCALE_MAX) ? VSCALE_MAX
                                                                        : cfg_data[9:0];
        REG_VEXP:      cfg_nxt.vexp      = (cfg_data[8:0] > VEXP_MAX) ? VEXP_MAX
                                                                      : cfg_data[8:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.coeff     <= RST_COEFF;
      cfg_r.thresh    <= RST_THRESH;
      cfg_r.off_ticks <= sat_cnt(RST_OFF, OFF_TICKS_MIN);
      cfg_r.vol_ticks <= sat_cnt(RST_VOL, VOL_TICKS_MIN);
      cfg_r.note      <= RST_NOTE;
      cfg_r.vmin      <= RST_VMIN;
      cfg_r.vscale    <= RST_VSCALE;
      cfg_r.vexp      <= RST_VEXP;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/rmsont_ctrl.sv
module rmsont_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  rmsont_pkg::sts_t   sts,
  output rmsont_pkg::cmd_t   cmd
);
  import rmsont_pkg::*;

  state_t                state_r, state_nxt;
  logic [NORM_CNT_W-1:0] norm_cnt_r, norm_cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      norm_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      norm_cnt_r <= norm_cnt_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    norm_cnt_nxt = norm_cnt_r;
    cmd          = '0;
    cmd.mul_sel  = MUL_NONE;
    cmd.norm_idx = norm_cnt_r;
    in_tready    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready       = 1'b1;
        cmd.load_sample = in_tvalid;
        if (in_tvalid) state_nxt = S_SQ;
      end
      S_SQ: begin
        cmd.mul_sel = MUL_SQ;
        state_nxt   = S_SQCAP;
      end
      S_SQCAP: begin
        cmd.cap_sq = 1'b1;
        state_nxt  = S_MSMUL;
      end
      S_MSMUL: begin
        cmd.mul_sel = MUL_COEF;
        state_nxt   = S_UPD;
      end
      S_UPD: begin
        cmd.upd_ms = 1'b1;
        state_nxt  = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (sts.note_on)       state_nxt = S_POW0;
        else if (sts.note_off) state_nxt = S_EMIT_OFF;
        else                   state_nxt = S_IDLE;
      end
      S_POW0: begin
        cmd.pow_init = 1'b1;
        norm_cnt_nxt = '0;
        state_nxt    = sts.pow_special ? S_SCALE : S_NORM;
      end
      S_NORM: begin
        cmd.norm_step = 1'b1;
        if (norm_cnt_r == NORM_CNT_W'(NORM_STEPS - 1)) begin
          state_nxt = S_LOGI;
        end else begin
          norm_cnt_nxt = norm_cnt_r + 1'b1;
        end
      end
      S_LOGI: begin
        cmd.mul_sel = MUL_LOGI;
        state_nxt   = S_LOGA;
      end
      S_LOGA: begin
        cmd.cap_lg = 1'b1;
        state_nxt  = S_LOGM;
      end
      S_LOGM: begin
        cmd.mul_sel = MUL_LOGE;
        state_nxt   = S_YCAP;
      end
      S_YCAP: begin
        cmd.cap_y = 1'b1;
        state_nxt = S_EXPI;
      end
      S_EXPI: begin
        cmd.mul_sel = MUL_EXPI;
        state_nxt   = S_EXPM;
      end
      S_EXPM: begin
        cmd.cap_pow = 1'b1;
        state_nxt   = S_SCALE;
      end
      S_SCALE: begin
        cmd.mul_sel = MUL_VSC;
        state_nxt   = S_VEL;
      end
      S_VEL: begin
        cmd.cap_vel = 1'b1;
        state_nxt   = S_EMIT_ON;
      end
      S_EMIT_ON: begin
        cmd.out_on = 1'b1;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_EMIT_OFF: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_norm_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_NORM) |-> (norm_cnt_r < NORM_CNT_W'(NORM_STEPS)))
    else $error("normalize step index out of range");

endmodule

// File: rtl/rmsont_dp.sv
module rmsont_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [rmsont_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  rmsont_pkg::cfg_t                   cfg,
  input  rmsont_pkg::cmd_t                   cmd,
  output rmsont_pkg::sts_t                   sts,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [rmsont_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import rmsont_pkg::*;

  // control and state registers
  logic [MS_W-1:0]       ms_r, ms_nxt;
  logic [MS_W-1:0]       prev_r, prev_nxt;
  logic [MS_W-1:0]       peak_r, peak_nxt;
  logic [COUNT_BITS-1:0] rel_r, rel_nxt;
  logic [COUNT_BITS-1:0] win_r, win_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // payload registers
  logic [SAMPLE_BITS-1:0]    samp_r, samp_nxt;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic [MS_W-1:0]           sq_r, sq_nxt;
  logic [31:0]               x_r, x_nxt;
  logic [4:0]                b_r, b_nxt;
  logic signed [LG_W-1:0]    lg_r, lg_nxt;
  logic signed [Y_W-1:0]     y_r, y_nxt;
  logic [POW_W-1:0]          pow_r, pow_nxt;
  logic [6:0]                vel_r, vel_nxt;
  logic [7:0]                out_status_r, out_status_nxt;
  logic [6:0]                out_note_r, out_note_nxt;
  logic [6:0]                out_vel_r, out_vel_nxt;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic [SAMPLE_BITS-1:0]    mag;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [DELTA_W-1:0] delta;
  logic signed [DELTA_W:0]   ms_sum;
  logic [MS_W-1:0]           ms_new;
  logic [3:0]                li, ei;
  logic [11:0]               lrem, erem;
  logic [TAB_W-1:0]          dlog, dexp;
  logic [INTERP_W-1:0]       interp;
  logic signed [6:0]         bm30;
  logic [TAB_W-1:0]          mant;
  logic signed [IP_W-1:0]    ip;
  logic [IP_W-1:0]           ipn;
  logic [31:0]               pow_w;
  logic [TERM_W-1:0]         term;
  logic [VSUM_W-1:0]         vsum;
  logic [4:0]                amt;
  logic                      top_zero;
  logic                      out_free;
  logic                      onset;

  // one-pole level update, saturated to 0..MS_MAX
  assign mag    = samp_r[SAMPLE_BITS-1] ? (~samp_r + 1'b1) : samp_r;
  assign diff   = $signed({2'b00, sq_r}) - $signed({2'b00, ms_r});
  assign delta  = prod_r[PROD_W-1:COEFF_W];
  assign ms_sum = (DELTA_W + 1)'(delta) + (DELTA_W + 1)'($signed({1'b0, ms_r}));

  always_comb begin
    if (ms_sum[DELTA_W])                ms_new = '0;
    else if (|ms_sum[DELTA_W-1:MS_W])   ms_new = MS_MAX;
    else                                ms_new = ms_sum[MS_W-1:0];
  end

  // log2 / exp2 table interpolation; x_r holds the peak normalized to bit 31
  assign li     = x_r[30:27];
  assign lrem   = x_r[26:15];
  assign dlog   = log_tab({1'b0, li} + 5'd1) - log_tab({1'b0, li});
  assign ei     = y_r[15:12];
  assign erem   = y_r[11:0];
  assign dexp   = exp_tab({1'b0, ei} + 5'd1) - exp_tab({1'b0, ei});
  assign interp = prod_r[12 +: INTERP_W];
  assign bm30   = $signed({2'b00, b_r}) - 7'sd30;
  assign mant   = exp_tab({1'b0, ei}) + TAB_W'(interp);
  assign ip     = y_r[Y_W-1:16];
  assign ipn    = IP_W'(-ip);
  assign term   = prod_r[16 +: TERM_W];
  assign vsum   = VSUM_W'(cfg.vmin) + VSUM_W'(term);

  always_comb begin
    if (!ip[IP_W-1])             pow_w = 32'(mant) << ip[4:0];
    else if (ipn > IP_W'(31))    pow_w = '0;
    else                         pow_w = 32'(mant) >> ipn[4:0];
  end

  // binary leading-one search: shift by 16, 8, 4, 2, 1
  assign amt      = 5'd16 >> cmd.norm_idx;
  assign top_zero = ~|(x_r & ~(32'hFFFF_FFFF >> amt));

  always_comb begin
    case (cmd.mul_sel)
      MUL_SQ: begin
        mul_a = MUL_A_W'(mag);
        mul_b = MUL_B_W'(mag);
      end
      MUL_COEF: begin
        mul_a = MUL_A_W'(diff);
        mul_b = MUL_B_W'(cfg.coeff);
      end
      MUL_LOGI: begin
        mul_a = MUL_A_W'(dlog);
        mul_b = MUL_B_W'(lrem);
      end
      MUL_LOGE: begin
        mul_a = MUL_A_W'(lg_r);
        mul_b = MUL_B_W'(cfg.vexp);
      end
      MUL_EXPI: begin
        mul_a = MUL_A_W'(dexp);
        mul_b = MUL_B_W'(erem);
      end
      MUL_VSC: begin
        mul_a = MUL_A_W'(pow_r);
        mul_b = MUL_B_W'(cfg.vscale);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;
  assign out_free = !out_valid_r || out_tready;
  assign onset    = (ms_r > cfg.thresh) && (prev_r < ms_r);

  always_comb begin
    samp_nxt       = samp_r;
    sq_nxt         = sq_r;
    ms_nxt         = ms_r;
    prev_nxt       = prev_r;
    peak_nxt       = peak_r;
    rel_nxt        = rel_r;
    win_nxt        = win_r;
    x_nxt          = x_r;
    b_nxt          = b_r;
    lg_nxt         = lg_r;
    y_nxt          = y_r;
    pow_nxt        = pow_r;
    vel_nxt        = vel_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_note_nxt   = out_note_r;
    out_vel_nxt    = out_vel_r;

    if (cmd.load_sample) samp_nxt = in_tdata[SAMPLE_BITS-1:0];
    if (cmd.cap_sq)      sq_nxt   = prod_r[SQ_SHIFT +: MS_W];
    if (cmd.upd_ms) begin
      prev_nxt = ms_r;
      ms_nxt   = ms_new;
    end

    if (cmd.decide) begin
      if ((win_r != '0) && (ms_r > peak_r)) peak_nxt = ms_r;
      if (rel_r != '0) begin
        if (win_r != '0) win_nxt = win_r - 1'b1;
        else             rel_nxt = rel_r - 1'b1;
      end else if (onset) begin
        rel_nxt  = cfg.off_ticks;
        win_nxt  = cfg.vol_ticks;
        peak_nxt = ms_r;
      end
    end

    if (cmd.pow_init) begin
      pow_nxt = (cfg.vexp == '0) ? POW_ONE : '0;
      x_nxt   = 32'(peak_r);
      b_nxt   = 5'd31;
    end
    if (cmd.norm_step && top_zero) begin
      x_nxt = x_r << amt;
      b_nxt = b_r - amt;
    end
    if (cmd.cap_lg)
      lg_nxt = $signed(LG_W'(log_tab({1'b0, li}))) + $signed(LG_W'(interp))
             + (LG_W'(bm30) <<< 16);
    if (cmd.cap_y)   y_nxt   = prod_r[8 +: Y_W];
    if (cmd.cap_pow) pow_nxt = pow_w[POW_W-1:0];
    if (cmd.cap_vel) vel_nxt = (vsum > VSUM_W'(VEL_MAX)) ? VEL_MAX : vsum[6:0];

    if (cmd.out_load) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = cmd.out_on ? STATUS_NOTE_ON : STATUS_NOTE_OFF;
      out_note_nxt   = cfg.note;
      out_vel_nxt    = cmd.out_on ? vel_r : 7'd0;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_r        <= '0;
      prev_r      <= '0;
      peak_r      <= '0;
      rel_r       <= '0;
      win_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ms_r        <= ms_nxt;
      prev_r      <= prev_nxt;
      peak_r      <= peak_nxt;
      rel_r       <= rel_nxt;
      win_r       <= win_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    samp_r       <= samp_nxt;
    prod_r       <= prod_nxt;
    sq_r         <= sq_nxt;
    x_r          <= x_nxt;
    b_r          <= b_nxt;
    lg_r         <= lg_nxt;
    y_r          <= y_nxt;
    pow_r        <= pow_nxt;
    vel_r        <= vel_nxt;
    out_status_r <= out_status_nxt;
    out_note_r   <= out_note_nxt;
    out_vel_r    <= out_vel_nxt;
  end

  always_comb begin
    sts.note_on     = (rel_r != '0) && (win_r == COUNT_BITS'(1));
    sts.note_off    = (rel_r != '0) && (win_r == '0) && (rel_r == COUNT_BITS'(1));
    sts.pow_special = (cfg.vexp == '0) || (peak_r == '0);
    sts.out_free    = out_free;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_vel_r, out_note_r, out_status_r};

  a_window_inside_release: assert property (@(posedge clk) disable iff (!rst_n)
    (win_r != '0) |-> (rel_r != '0))
    else $error("volume window open without a pending note-off");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> out_free)
    else $error("result register overwritten before transfer");

  a_note_on_velocity: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == STATUS_NOTE_ON)) |-> (out_vel_r != '0))
    else $error("note-on with zero velocity");

endmodule

// File: rtl/rms_onset_note_trigger.sv
// A note-off is loaded into out_tdata after the square, smoothing and decision steps, a note-on
// after those and the leading-one search, log2, power and velocity steps (only the velocity step
// when the exponent or the peak is zero); either waits for the prior result's transfer. No new
// sample is taken until the last is done; the one shared 33x25 multiplier and the 5-step leading-one search set this.
// Reset (rst_n, synchronous, active low): level, peak and counters clear, output goes
// empty, configuration registers take their default values.
module rms_onset_note_trigger (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [rmsont_pkg::IN_TDATA_W-1:0]  in_tdata,   // [23:0] filtered_sample
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [rmsont_pkg::OUT_TDATA_W-1:0] out_tdata,  // [7:0] status_byte, [14:8] note,
                                                         // [21:15] velocity
  input  logic                               cfg_we,
  input  logic [rmsont_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rmsont_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rmsont_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  rmsont_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rmsont_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rmsont_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg        (cfg),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// File: tb/onset_event_checker.sv
`timescale 1ns / 1ps

module onset_event_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  input  logic                                in_tready,
  input  logic [rmsont_pkg::IN_TDATA_W-1:0]  in_tdata,    // [23:0] filtered_sample
  input  logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic [rmsont_pkg::OUT_TDATA_W-1:0] out_tdata,   // [7:0] status_byte, [14:8] note,
                                                           // [21:15] velocity
  input  logic                                cfg_we,
  input  logic [rmsont_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rmsont_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                                  fail_count,
  output int                                  events_due,
  output int                                  events_seen
);
  import rmsont_pkg::*;

  typedef struct packed {
    logic [7:0] status;
    logic [6:0] note;
    logic [6:0] velocity;
  } note_event_t;

  // log2(1 + k/16) and 2^(k/16), both Q16
  localparam logic [31:0] LOG2_Q16 [17] = '{
    0, 5732, 11136, 16248, 21098, 25711, 30109, 34312, 38336,
    42196, 45904, 49473, 52911, 56229, 59434, 62535, 65536
  };
  localparam logic [31:0] EXP2_Q16 [17] = '{
    65536, 68438, 71468, 74632, 77936, 81386, 84990, 88752,
    92682, 96785, 101070, 105545, 110218, 115098, 120194, 125515, 131072
  };

  logic [COEFF_W-1:0] coeff;
  logic [MS_W-1:0]    thresh;
  logic [15:0]        off_ticks, vol_ticks;
  logic [6:0]         note_num, vmin;
  logic [9:0]         vscale;
  logic [8:0]         vexp;

  logic [31:0] level, peak;
  logic [15:0] release_left, window_left;

  note_event_t expected_events[$];
  int          mismatches;
  int          arrived;

  // peak (Q2.30) to the power ex (Q1.8), Q16 result
  function automatic logic [31:0] peak_power(input logic [31:0] p, input logic [8:0] ex);
    int          msb;
    logic [31:0] frac, idx, rem, mant;
    longint      lg, y, ip;
    if (ex == 0) return 32'd65536;
    if (p == 0) return 32'd0;
    msb = 31;
    while (p[msb] == 1'b0) msb--;
    if (msb >= 16) frac = (p >> (msb - 16)) & 32'hFFFF;
    else frac = (p << (16 - msb)) & 32'hFFFF;
    idx = frac >> 12;
    rem = frac & 32'hFFF;
    lg = longint'(LOG2_Q16[idx] + (((LOG2_Q16[idx+1] - LOG2_Q16[idx]) * rem) >> 12));
    lg = lg + longint'(msb - 30) * 65536;
    y = (lg * longint'(ex)) >>> 8;
    ip = y >>> 16;
    frac = 32'(y - ip * 65536);
    idx = frac >> 12;
    rem = frac & 32'hFFF;
    mant = EXP2_Q16[idx] + (((EXP2_Q16[idx+1] - EXP2_Q16[idx]) * rem) >> 12);
    if (ip >= 0) return mant << ip;
    if (ip < -31) return 32'd0;
    return mant >> (-ip);
  endfunction

  function automatic logic [6:0] note_velocity(input logic [31:0] pk);
    logic [6:0]  lo;
    logic [9:0]  sc;
    logic [8:0]  ex;
    logic [63:0] term, vel;
    lo = (vmin < 7'd1) ? 7'd1 : vmin;
    sc = (vscale > VSCALE_MAX) ? VSCALE_MAX : vscale;
    ex = (vexp > VEXP_MAX) ? VEXP_MAX : vexp;
    term = (64'(peak_power(pk, ex)) * 64'(sc)) >> 16;
    vel = 64'(lo) + term;
    if (vel > 64'd127) vel = 64'd127;
    return vel[6:0];
  endfunction

  task automatic take_sample(input logic [23:0] s);
    logic [23:0] mag;
    longint      sq, lvl;
    logic [31:0] prev;
    note_event_t ev;
    mag = s[23] ? (~s + 24'd1) : s;
    sq = (longint'(mag) * longint'(mag)) >> 16;
    prev = level;
    lvl = longint'(prev) + (((sq - longint'(prev)) * longint'(coeff)) >>> 24);
    if (lvl < 0) lvl = 0;
    if (lvl > 64'sh7FFFFFFF) lvl = 64'sh7FFFFFFF;
    level = lvl[31:0];

    if (window_left != 0 && level > peak) peak = level;

    if (release_left != 0) begin
      if (window_left != 0) begin
        window_left = window_left - 16'd1;
        if (window_left == 0) begin
          ev.status = STATUS_NOTE_ON;
          ev.note = note_num;
          ev.velocity = note_velocity(peak);
          expected_events.push_back(ev);
        end
      end else begin
        release_left = release_left - 16'd1;
        if (release_left == 0) begin
          ev.status = STATUS_NOTE_OFF;
          ev.note = note_num;
          ev.velocity = 7'd0;
          expected_events.push_back(ev);
        end
      end
    end else if (level > 32'(thresh) && prev < level) begin
      // onset: arm the volume window and the note-off countdown
      release_left = (off_ticks < OFF_TICKS_MIN) ? OFF_TICKS_MIN : off_ticks;
      window_left = (vol_ticks < VOL_TICKS_MIN) ? VOL_TICKS_MIN : vol_ticks;
      peak = level;
    end
  endtask

  task automatic check_event(input logic [OUT_TDATA_W-1:0] d);
    note_event_t ev;
    arrived++;
    if (expected_events.size() == 0) begin
      $error("unexpected event: status_byte %0h note %0d velocity %0d",
             d[7:0], d[14:8], d[21:15]);
      mismatches++;
    end else begin
      ev = expected_events.pop_front();
      if (d[7:0] !== ev.status) begin
        $error("status_byte: expected %0h, actual %0h", ev.status, d[7:0]);
        mismatches++;
      end
      if (d[14:8] !== ev.note) begin
        $error("note: expected %0d, actual %0d", ev.note, d[14:8]);
        mismatches++;
      end
      if (d[21:15] !== ev.velocity) begin
        $error("velocity: expected %0d, actual %0d", ev.velocity, d[21:15]);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      coeff = RST_COEFF;
      thresh = RST_THRESH;
      off_ticks = RST_OFF;
      vol_ticks = RST_VOL;
      note_num = RST_NOTE;
      vmin = RST_VMIN;
      vscale = RST_VSCALE;
      vexp = RST_VEXP;
      level = '0;
      peak = '0;
      release_left = '0;
      window_left = '0;
      expected_events.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SMOOTH:    coeff = cfg_data[23:0];
          REG_THRESH:    thresh = cfg_data[30:0];
          REG_OFF_TICKS: off_ticks = cfg_data[15:0];
          REG_VOL_TICKS: vol_ticks = cfg_data[15:0];
          REG_NOTE:      note_num = cfg_data[6:0];
          REG_VMIN:      vmin = cfg_data[6:0];
          REG_VSCALE:    vscale = cfg_data[9:0];
          REG_VEXP:      vexp = cfg_data[8:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) take_sample(in_tdata[23:0]);
      if (out_tvalid && out_tready) check_event(out_tdata);
    end
    fail_count <= mismatches;
    events_due <= expected_events.size();
    events_seen <= arrived;
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import rmsont_pkg::*;

  localparam int ITEM_TARGET  = 1350;
  localparam int PHASE_ITEMS  = 110;
  localparam int MAX_PHASES   = 30;
  localparam int MIN_EVENTS   = 60;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;    // [23:0] filtered_sample
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;        // [7:0] status_byte, [14:8] note, [21:15] velocity
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int fail_count, events_due, events_seen;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int samples_sent = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  rms_onset_note_trigger u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  onset_event_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .events_due  (events_due),
    .events_seen (events_seen)
  );

  initial begin
    #4_000_000;
    $display("rms_onset_note_trigger test failed");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_ack != hold_req) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic set_pace(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
      1: begin send_idle_pct = 48; recv_stall_pct <= 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct <= 48; end
      default: begin send_idle_pct = 32; recv_stall_pct <= 32; end
    endcase
  endtask

  task automatic send_sample(input logic [23:0] s);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= s;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    samples_sent++;
  endtask

  function automatic logic [23:0] signed_sample(input int unsigned mag);
    if ($urandom_range(0, 1)) return 24'(-int'(mag));
    return 24'(mag);
  endfunction

  // quiet stretch then a loud stretch; now and then plain noise
  task automatic send_burst();
    int unsigned amp;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 20)) send_sample(24'($urandom));
    end else begin
      repeat ($urandom_range(0, 16)) send_sample(signed_sample($urandom_range(0, 4095)));
      amp = $urandom_range(1 << 12, 8388607);
      repeat ($urandom_range(1, 24)) send_sample(signed_sample($urandom_range(amp / 4, amp)));
    end
  endtask

  // wait until every expected event has transferred and the block is quiet
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (events_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_reg_t r, input logic [30:0] v, input int width,
                         input bit junk);
    logic [30:0] m, d;
    m = (31'h1 << width) - 31'h1;
    d = junk ? 31'($urandom) : '0;
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= (d & ~m) | (v & m);
    @(posedge clk);
  endtask

  task automatic apply_config(input cfg_t c, input bit junk);
    put_reg(REG_SMOOTH, 31'(c.coeff), COEFF_W, junk);
    put_reg(REG_THRESH, 31'(c.thresh), MS_W, junk);
    put_reg(REG_OFF_TICKS, 31'(c.off_ticks), 16, junk);
    put_reg(REG_VOL_TICKS, 31'(c.vol_ticks), 16, junk);
    put_reg(REG_NOTE, 31'(c.note), 7, junk);
    put_reg(REG_VMIN, 31'(c.vmin), 7, junk);
    put_reg(REG_VSCALE, 31'(c.vscale), 10, junk);
    put_reg(REG_VEXP, 31'(c.vexp), 9, junk);
    cfg_we <= 1'b0;
  endtask

  function automatic cfg_t random_config();
    cfg_t c;
    if ($urandom_range(0, 4) == 0) c.coeff = 24'($urandom_range(1, 24'h3FFFF));
    else c.coeff = 24'($urandom_range(24'h40000, 24'hFFFFFF));
    case ($urandom_range(0, 9))
      0: c.thresh = '0;
      1: c.thresh = 31'($urandom);
      2: c.thresh = 31'd1 << 30;
      default: c.thresh = 31'($urandom_range(1, 1 << 27));
    endcase
    if ($urandom_range(0, 9) == 0) c.off_ticks = 16'($urandom_range(0, 4));
    else c.off_ticks = 16'($urandom_range(5, 40));
    if ($urandom_range(0, 9) == 0) c.vol_ticks = '0;
    else c.vol_ticks = 16'($urandom_range(1, 24));
    c.note = 7'($urandom_range(0, 127));
    if ($urandom_range(0, 3) == 0) c.vmin = 7'($urandom_range(0, 127));
    else c.vmin = 7'($urandom_range(0, 40));
    if ($urandom_range(0, 9) == 0) c.vscale = 10'($urandom_range(541, 1023));
    else c.vscale = 10'($urandom_range(0, 540));
    if ($urandom_range(0, 9) == 0) c.vexp = 9'($urandom_range(257, 511));
    else c.vexp = 9'($urandom_range(0, 256));
    return c;
  endfunction

  initial begin
    cfg_t cfg;
    int   phase;
    int   start;
    bit   paused;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    set_pace(0);

    // reset defaults: input extremes, kept below the default threshold
    send_sample(24'h000000);
    send_sample(24'h000001);
    send_sample(24'hFFFFFF);
    send_sample(24'h555555);
    send_sample(24'hAAAAAA);
    send_sample(24'h7FFFFF);
    send_sample(24'h800000);
    settle();

    // zero exponent, scale and minimum past their limits, tick floors
    cfg = '{coeff: 24'hFFFFFF, thresh: '0, off_ticks: '0, vol_ticks: '0, note: 7'd127,
            vmin: 7'd0, vscale: 10'd1023, vexp: 9'd0};
    apply_config(cfg, 1'b0);
    send_sample(24'h000000);
    send_sample(24'h7FFFFF);
    repeat (6) send_sample(24'h000000);
    settle();

    // slowest smoothing, tiny peak, exponent past one
    cfg = '{coeff: 24'd1, thresh: '0, off_ticks: 16'd5, vol_ticks: 16'd1, note: 7'd0,
            vmin: 7'd127, vscale: 10'd0, vexp: 9'd511};
    apply_config(cfg, 1'b0);
    send_sample(24'h000000);
    send_sample(24'h800000);
    repeat (6) send_sample(24'h000000);

    phase = 0;
    paused = 1'b0;
    while ((samples_sent < ITEM_TARGET || events_seen < MIN_EVENTS) && phase < MAX_PHASES) begin
      cfg = random_config();
      if (phase == 2) begin
        // short notes so the held-off output backs up into the input
        cfg.coeff = 24'hFFFFFF;
        cfg.thresh = 31'd1 << 20;
        cfg.vol_ticks = 16'd1;
        cfg.off_ticks = 16'd5;
      end
      if (phase == 7) begin
        // longest counts; threshold above any reachable level
        cfg.coeff = 24'hFFFFFF;
        cfg.thresh = 31'h7FFFFFFF;
        cfg.off_ticks = 16'hFFFF;
        cfg.vol_ticks = 16'hFFFF;
      end
      settle();
      apply_config(cfg, phase % 3 == 1);
      set_pace(phase % 4);
      if (phase == 2) hold_req <= hold_req + 1;
      start = samples_sent;
      while (samples_sent - start < PHASE_ITEMS) begin
        send_burst();
        if (phase == 5 && !paused && samples_sent - start >= PHASE_ITEMS / 2) begin
          paused = 1'b1;
          in_tvalid <= 1'b0;
          @(posedge clk);
          while (events_due != 0) @(posedge clk);
        end
      end
      phase++;
    end

    settle();
    if (fail_count == 0 && events_due == 0) begin
      $display("rms_onset_note_trigger test passed");
    end else begin
      $display("rms_onset_note_trigger test failed");
    end
    $finish;
  end

endmodule
